FILE: hw/rtl/ookenc_pkg.sv
// Shared types, constants and helpers of the OOK remote code pulse encoder.
package ookenc_pkg;

   localparam int CODE_BITS_DEFAULT = 12;
   localparam int CODE_WORD_WIDTH   = 12;
   localparam int UNIT_TICKS_WIDTH  = 16;
   localparam int REPEATS_WIDTH     = 4;
   localparam int UNITS_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = UNIT_TICKS_WIDTH;

   localparam logic [UNIT_TICKS_WIDTH-1:0] UNIT_TICKS_RESET    = 16'd350;
   localparam logic [REPEATS_WIDTH-1:0]    FRAME_REPEATS_RESET = 4'd6;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNIT_TICKS    = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_REPEATS = 1'd1;

   localparam logic [1:0] PHASE_FIRST_HIGH  = 2'd0;
   localparam logic [1:0] PHASE_FIRST_LOW   = 2'd1;
   localparam logic [1:0] PHASE_SECOND_HIGH = 2'd2;
   localparam logic [1:0] PHASE_SECOND_LOW  = 2'd3;

   localparam logic [UNITS_WIDTH-1:0] UNITS_SHORT     = 5'd1;
   localparam logic [UNITS_WIDTH-1:0] UNITS_LONG      = 5'd3;
   localparam logic [UNITS_WIDTH-1:0] UNITS_SYNC_LOW  = 5'd31;

   typedef struct packed {
      logic                       start_req;
      logic [CODE_WORD_WIDTH-1:0] code_word;
   } req_word_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
   } rsp_word_type;

   typedef struct packed {
      logic advance;
   } flow_type;

   // Units in the segment selected by phase, sync flag and current code bit.
   function automatic logic [UNITS_WIDTH-1:0] seg_units(
      input logic       is_sync,
      input logic [1:0] phase,
      input logic       code_bit
   );
      logic [UNITS_WIDTH-1:0] units;
      begin
         if (is_sync) begin
            units = (phase == PHASE_FIRST_HIGH) ? UNITS_SHORT : UNITS_SYNC_LOW;
         end else begin
            case (phase)
               PHASE_FIRST_HIGH:  units = UNITS_SHORT;
               PHASE_FIRST_LOW:   units = UNITS_LONG;
               PHASE_SECOND_HIGH: units = code_bit ? UNITS_SHORT : UNITS_LONG;
               PHASE_SECOND_LOW:  units = code_bit ? UNITS_LONG : UNITS_SHORT;
               default:           units = UNITS_SHORT;
            endcase
         end
         return units;
      end
   endfunction

endpackage

FILE: hw/rtl/ookenc_in_reg.sv
// Input register of the request channel and the pipeline advance control.
module ookenc_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ookenc_pkg::req_word_type req_word,
   input  logic                  out_free,
   output ookenc_pkg::flow_type  flow,
   output ookenc_pkg::req_word_type word
);
   import ookenc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         advance;

   assign advance   = valid_ff & out_free;
   assign req_ready = ~valid_ff | advance;
   assign valid_in  = req_valid | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

   assign flow.advance  = advance;
   assign word          = word_ff;

endmodule

FILE: hw/rtl/ookenc_seq.sv
// Frame sequencer: settings registers, pulse state and one tick of line output.
module ookenc_seq #(
   parameter int CODE_BITS = ookenc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ookenc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ookenc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  ookenc_pkg::flow_type                  flow,
   input  ookenc_pkg::req_word_type              word,
   output ookenc_pkg::rsp_word_type              result
);
   import ookenc_pkg::*;

   localparam int BP_WIDTH = $clog2(CODE_BITS + 1);
   localparam logic [BP_WIDTH-1:0] SYNC_POS = BP_WIDTH'(CODE_BITS);

   logic [UNIT_TICKS_WIDTH-1:0] unit_ticks_ff;
   logic [REPEATS_WIDTH-1:0]    frame_repeats_ff;

   logic [CODE_BITS-1:0]        code_ff, code_in;
   logic [BP_WIDTH-1:0]         bp_ff, bp_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [UNITS_WIDTH-1:0]      units_ff, units_in;
   logic [UNIT_TICKS_WIDTH-1:0] pre_ff, pre_in;
   logic [REPEATS_WIDTH-1:0]    rep_ff, rep_in;
   logic                        active_ff, active_in;

   logic [CODE_BITS-1:0]        s_code;
   logic [BP_WIDTH-1:0]         s_bp;
   logic [1:0]                  s_phase;
   logic [UNITS_WIDTH-1:0]      s_units;
   logic [UNIT_TICKS_WIDTH-1:0] s_pre;
   logic [REPEATS_WIDTH-1:0]    s_rep;
   logic                        s_active;

   logic [CODE_BITS+CODE_WORD_WIDTH-1:0] code_wide;
   logic [UNIT_TICKS_WIDTH-1:0] unit_len;
   logic [REPEATS_WIDTH-1:0]    target;
   logic [REPEATS_WIDTH-1:0]    rep_next;
   logic                        seg_start;

   assign unit_len  = (unit_ticks_ff == '0) ? UNIT_TICKS_WIDTH'(1) : unit_ticks_ff;
   assign target    = (frame_repeats_ff == '0) ? REPEATS_WIDTH'(1) : frame_repeats_ff;
   assign code_wide = {{CODE_BITS{1'b0}}, word.code_word};

   always_comb begin
      // take a start request only while idle
      s_code   = code_ff;
      s_bp     = bp_ff;
      s_phase  = phase_ff;
      s_units  = units_ff;
      s_pre    = pre_ff;
      s_rep    = rep_ff;
      s_active = active_ff;
      if (!active_ff && word.start_req) begin
         s_code   = code_wide[CODE_BITS-1:0];
         s_bp     = '0;
         s_phase  = PHASE_FIRST_HIGH;
         s_rep    = '0;
         s_active = 1'b1;
         s_units  = UNITS_SHORT;
         s_pre    = unit_len;
      end

      result.line_level = s_active & ~s_phase[0];
      result.busy_res   = s_active;

      code_in   = s_code;
      bp_in     = s_bp;
      phase_in  = s_phase;
      units_in  = s_units;
      pre_in    = s_pre;
      rep_in    = s_rep;
      active_in = s_active;
      rep_next  = s_rep + REPEATS_WIDTH'(1);
      seg_start = 1'b0;

      if (s_active) begin
         if (s_pre > UNIT_TICKS_WIDTH'(1)) begin
            pre_in = s_pre - UNIT_TICKS_WIDTH'(1);
         end else begin
            pre_in = unit_len;
            if (s_units > UNITS_WIDTH'(1)) begin
               units_in = s_units - UNITS_WIDTH'(1);
            end else if (s_bp != SYNC_POS) begin
               seg_start = 1'b1;
               if (s_phase != PHASE_SECOND_LOW) begin
                  phase_in = s_phase + 2'd1;
               end else begin
                  // rotate so the code is whole again after the last bit
                  phase_in = PHASE_FIRST_HIGH;
                  bp_in    = s_bp + BP_WIDTH'(1);
                  code_in  = {s_code[CODE_BITS-2:0], s_code[CODE_BITS-1]};
               end
            end else if (s_phase == PHASE_FIRST_HIGH) begin
               seg_start = 1'b1;
               phase_in  = PHASE_FIRST_LOW;
            end else begin
               rep_in   = rep_next;
               phase_in = PHASE_FIRST_HIGH;
               bp_in    = '0;
               if (rep_next >= target) begin
                  active_in = 1'b0;
                  units_in  = '0;
                  pre_in    = '0;
               end else begin
                  seg_start = 1'b1;
               end
            end
         end
      end

      if (seg_start) begin
         units_in = seg_units(bp_in == SYNC_POS, phase_in, code_in[CODE_BITS-1]);
         pre_in   = unit_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff    <= UNIT_TICKS_RESET;
         frame_repeats_ff <= FRAME_REPEATS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UNIT_TICKS:    unit_ticks_ff    <= csr_wdata;
            CSR_FRAME_REPEATS: frame_repeats_ff <= csr_wdata[REPEATS_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff   <= '0;
         bp_ff     <= '0;
         phase_ff  <= PHASE_FIRST_HIGH;
         units_ff  <= '0;
         pre_ff    <= '0;
         rep_ff    <= '0;
         active_ff <= 1'b0;
      end else if (flow.advance) begin
         code_ff   <= code_in;
         bp_ff     <= bp_in;
         phase_ff  <= phase_in;
         units_ff  <= units_in;
         pre_ff    <= pre_in;
         rep_ff    <= rep_in;
         active_ff <= active_in;
      end
   end

endmodule

FILE: hw/rtl/ookenc_out_reg.sv
// Output register of the response channel.
module ookenc_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  ookenc_pkg::flow_type     flow,
   input  ookenc_pkg::rsp_word_type result,
   output logic                     out_free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ookenc_pkg::rsp_word_type rsp_word
);
   import ookenc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign out_free = ~valid_ff | rsp_ready;
   assign valid_in = flow.advance | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.advance) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

FILE: hw/rtl/ook_remote_code_pulse_encoder_core.sv
// Top level of the OOK remote code pulse encoder.
//
//   port group   direction  meaning
//   req_*        in         one timebase tick: start request and code
//   rsp_*        out        line level and busy flag for that tick
//   csr_*        in         settings write: unit length, frame count
//
// One word in, one word out; a new word is taken every cycle unless a stalled response holds the pipeline.
// A word passes two registers: input register, then output register.
// Reset is synchronous; it restores the default settings and goes idle.
// A stalled response holds the pipeline; the request side stalls only when
// both registers are full.
module ook_remote_code_pulse_encoder_core #(
   parameter int CODE_BITS = ookenc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ookenc_pkg::req_word_type              req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ookenc_pkg::rsp_word_type              rsp_word,
   input  logic                                  csr_we,
   input  logic [ookenc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ookenc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import ookenc_pkg::*;

   flow_type     flow;
   req_word_type word;
   rsp_word_type result;
   logic         out_free;

   ookenc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .out_free  (out_free),
      .flow      (flow),
      .word      (word)
   );

   ookenc_seq #(
      .CODE_BITS (CODE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .flow      (flow),
      .word      (word),
      .result    (result)
   );

   ookenc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: sim/tb.sv
// Self-checking bench for the OOK remote code pulse encoder with random stalls.
module tb;
   import ookenc_pkg::*;

   localparam int NBITS = CODE_BITS_DEFAULT;

   class pulse_line_tracker;
      logic [UNIT_TICKS_WIDTH-1:0] unit_ticks;
      logic [REPEATS_WIDTH-1:0]    frame_repeats;
      logic [CODE_WORD_WIDTH-1:0]  code;
      logic [4:0]                  bit_pos;
      logic [1:0]                  phase;
      logic [UNITS_WIDTH-1:0]      units_left;
      logic [UNIT_TICKS_WIDTH-1:0] prescale;
      logic [REPEATS_WIDTH-1:0]    frames_sent;
      bit                          active;
      rsp_word_type                line_words_due[$];
      int                          errors;

      function new();
         unit_ticks    = UNIT_TICKS_RESET;
         frame_repeats = FRAME_REPEATS_RESET;
         code          = '0;
         bit_pos       = '0;
         phase         = PHASE_FIRST_HIGH;
         units_left    = '0;
         prescale      = '0;
         frames_sent   = '0;
         active        = 1'b0;
         errors        = 0;
      endfunction

      function void set_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
         if (idx == CSR_UNIT_TICKS) begin
            unit_ticks = data;
         end else if (idx == CSR_FRAME_REPEATS) begin
            frame_repeats = data[REPEATS_WIDTH-1:0];
         end
      endfunction

      function logic [UNIT_TICKS_WIDTH-1:0] unit_len();
         return (unit_ticks == '0) ? 16'd1 : unit_ticks;
      endfunction

      function logic [UNITS_WIDTH-1:0] segment_len();
         logic b;
         if (bit_pos >= NBITS) begin
            return (phase == PHASE_FIRST_HIGH) ? UNITS_SHORT : UNITS_SYNC_LOW;
         end
         b = code[NBITS - 1 - int'(bit_pos)];
         case (phase)
            PHASE_FIRST_HIGH:  return UNITS_SHORT;
            PHASE_FIRST_LOW:   return UNITS_LONG;
            PHASE_SECOND_HIGH: return b ? UNITS_SHORT : UNITS_LONG;
            default:           return b ? UNITS_LONG : UNITS_SHORT;
         endcase
      endfunction

      function void load_segment();
         units_left = segment_len();
         prescale   = unit_len();
      endfunction

      function void next_segment();
         logic [REPEATS_WIDTH-1:0] target;
         target = (frame_repeats == '0) ? 4'd1 : frame_repeats;
         if (bit_pos < NBITS) begin
            if (phase != PHASE_SECOND_LOW) begin
               phase = phase + 2'd1;
            end else begin
               phase   = PHASE_FIRST_HIGH;
               bit_pos = bit_pos + 5'd1;
            end
         end else if (phase == PHASE_FIRST_HIGH) begin
            phase = PHASE_FIRST_LOW;
         end else begin
            frames_sent = frames_sent + 4'd1;
            phase       = PHASE_FIRST_HIGH;
            bit_pos     = '0;
            if (frames_sent >= target) begin
               active     = 1'b0;
               units_left = '0;
               prescale   = '0;
               return;
            end
         end
         load_segment();
      endfunction

      function void take_tick(input req_word_type w);
         rsp_word_type due;
         if (!active && w.start_req) begin
            code        = w.code_word;
            bit_pos     = '0;
            phase       = PHASE_FIRST_HIGH;
            frames_sent = '0;
            active      = 1'b1;
            load_segment();
         end
         due = '0;
         if (active) begin
            due.line_level = ~phase[0];
            due.busy_res   = 1'b1;
            if (prescale > 16'd1) begin
               prescale = prescale - 16'd1;
            end else begin
               prescale = unit_len();
               if (units_left > 5'd1) begin
                  units_left = units_left - 5'd1;
               end else begin
                  next_segment();
               end
            end
         end
         line_words_due.push_back(due);
      endfunction

      function void note_error(input string msg);
         errors++;
         if (errors <= 10) begin
            $display("mismatch: %s", msg);
         end
      endfunction

      function void match_word(input rsp_word_type got);
         rsp_word_type due;
         if (line_words_due.size() == 0) begin
            note_error($sformatf("word with none due, line_level %b busy_res %b",
                                 got.line_level, got.busy_res));
            return;
         end
         due = line_words_due.pop_front();
         if (got.line_level !== due.line_level) begin
            note_error($sformatf("line_level expected %b actual %b",
                                 due.line_level, got.line_level));
         end
         if (got.busy_res !== due.busy_res) begin
            note_error($sformatf("busy_res expected %b actual %b",
                                 due.busy_res, got.busy_res));
         end
      endfunction

      function bit busy();
         return active;
      endfunction
   endclass

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_word  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_UNIT_TICKS;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   pulse_line_tracker tracker;
   bit                calm          = 1'b0;
   bit                long_hold_req = 1'b0;

   ook_remote_code_pulse_encoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type random_word(input int start_odds);
      req_word_type w;
      w.start_req = ($urandom_range(0, start_odds - 1) == 0);
      w.code_word = 12'($urandom_range(0, 4095));
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_tick(w);
   endtask

   task automatic send_start(input logic [CODE_WORD_WIDTH-1:0] code);
      req_word_type w;
      w.start_req = 1'b1;
      w.code_word = code;
      send_word(w);
   endtask

   task automatic send_idle(input int count);
      req_word_type w;
      w.start_req = 1'b0;
      w.code_word = 12'hFFF;
      repeat (count) send_word(w);
   endtask

   task automatic drain();
      while (tracker.busy()) send_word(random_word(2));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.line_words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.set_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            tracker.match_word(rsp_word);
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            if (long_hold_req) begin
               long_hold_req = 1'b0;
               hold_left     = 60;
            end else if (hold_left == 0) begin
               hold_left = pick_gap();
            end
            if (hold_left > 0) begin
               rsp_ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle ticks, then a three-frame request
      send_idle(3);
      settle();
      write_reg(CSR_UNIT_TICKS, 16'd1);
      write_reg(CSR_FRAME_REPEATS, 16'd3);
      long_hold_req = 1'b1;
      send_start(12'h5A3);
      repeat (140) send_word(random_word(2));
      settle();

      // zero unit length and zero frame count, taken mid-transmission
      write_reg(CSR_UNIT_TICKS, 16'd0);
      write_reg(CSR_FRAME_REPEATS, 16'hFFF0);
      drain();

      // restart on the first idle tick, then a longer unit mid-frame
      calm = 1'b1;
      send_start(12'hA5C);
      repeat (20) send_word(random_word(2));
      calm = 1'b0;
      repeat (80) send_word(random_word(2));
      settle();
      write_reg(CSR_UNIT_TICKS, 16'd2);
      drain();
      send_idle(3);

      settle();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.line_words_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(30_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
